// ===== design/bfmc_pkg.sv =====
// Package with the shared constants, types and helper functions of the mip chain.
`timescale 1ns / 1ps

package bfmc_pkg;

    localparam int MAX_DIM     = 1024;
    localparam int MAX_LEVELS  = 10;

    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int COORD_W     = $clog2(MAX_DIM);
    localparam int OUT_COORD_W = 9;
    localparam int LEVEL_W     = 4;
    localparam int STAGE_W     = $clog2(MAX_LEVELS);

    localparam int PIX_W       = 32;
    localparam int CH_N        = 4;
    localparam int CH_W        = 8;
    localparam int HSUM_CH_W   = CH_W + 2;
    localparam int HSUM_W      = CH_N * HSUM_CH_W;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 11;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

    // Frame geometry as seen by the back end.
    typedef struct packed {
        logic [DIM_W-1:0]   w0;
        logic [DIM_W-1:0]   h0;
        logic [LEVEL_W-1:0] nlev;
        logic               clear;
    } shape_t;

    // Size of a level: the level 0 size shifted down, never below one.
    function automatic logic [DIM_W-1:0] dim_at(input logic [DIM_W-1:0] d,
                                                input logic [LEVEL_W-1:0] k);
        logic [DIM_W-1:0] q;
        q = d >> k;
        return (q == '0) ? DIM_W'(1) : q;
    endfunction

    // A zero register reads as one, anything past the maximum saturates.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (32'(v) > MAX_DIM)
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== design/bfmc_if.sv =====
// Channel interfaces of the mip chain: pixel input, mip result output, register writes.
`timescale 1ns / 1ps

interface bfmc_pix_if import bfmc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface bfmc_mip_if import bfmc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [LEVEL_W-1:0]     level;
    logic [OUT_COORD_W-1:0] col;
    logic [OUT_COORD_W-1:0] row;
    logic [PIX_W-1:0]       mip_pixel;
    logic                   image_done;
    logic                   last_of_run;

    modport source (output valid, output level, output col, output row,
                    output mip_pixel, output image_done, output last_of_run,
                    input ready);
    modport sink   (input valid, input level, input col, input row,
                    input mip_pixel, input image_done, input last_of_run,
                    output ready);
endinterface

interface bfmc_cfg_if import bfmc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/box_filter_mip_chain_core.sv =====
// Top level of the streaming 2x2 box filter mip chain generator.
//
// Level 0 RGBA8 pixels enter in raster order on the pix channel, one request
// per pixel. For each one the block returns on the mip channel every lower
// level pixel that the pixel completes, level 1 first, with its level,
// column, row and averaged value; last_of_run marks the final result of the
// request and image_done the pixel of the last level of the frame.
// Image sizes are set on the cfg channel (index 0 width, index 1 height);
// a write restarts the frame and must only be issued while the block is idle.
// The back end takes one request at a time from the queue and walks its stages
// in turn. A result whose upper row comes back from the line store RAM, whose
// read is registered, passes through an extra vertical state, and a run that
// ends after a result goes through a flush state.
// Reset sets both sizes to 1024 and puts every stage at the frame start; the
// line store holds no defined data, and each entry is written before use.
// When the receiver stalls, the output register holds its result, one more
// result waits in the pending slot, and the four-entry queue takes new
// requests until it fills, after which pix.ready drops.
`timescale 1ns / 1ps

module box_filter_mip_chain_core import bfmc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    bfmc_cfg_if.sink   cfg,
    bfmc_pix_if.sink   pix,
    bfmc_mip_if.source mip
);

    logic             q_full;
    logic             q_push;
    logic [PIX_W-1:0] q_push_data;
    logic             q_pop;
    logic [PIX_W-1:0] q_pop_data;
    logic             q_not_empty;
    shape_t           shape;

    // Front end: owns the size registers and takes pixel requests.
    bfmc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .pix    (pix),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_push_data),
        .shape  (shape)
    );

    // The queue lets intake continue while the back end waits on the receiver.
    bfmc_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_not_empty)
    );

    // Back end: walks the stages of the chain and holds the line store.
    bfmc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .shape   (shape),
        .q_valid (q_not_empty),
        .q_data  (q_pop_data),
        .q_pop   (q_pop),
        .mip     (mip)
    );

endmodule

// ===== design/bfmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bfmc_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bfmc_fifo.sv =====
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps

module bfmc_fifo import bfmc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [PIX_W-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [PIX_W-1:0] pop_data,
    output logic             not_empty
);

    logic [PIX_W-1:0]    mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QUEUE_AW + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QUEUE_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

endmodule

// ===== design/bfmc_front.sv =====
// Front end: size registers, level count decode and pixel request intake.
`timescale 1ns / 1ps

module bfmc_front import bfmc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    bfmc_cfg_if.sink         cfg,
    bfmc_pix_if.sink         pix,
    input  logic             q_full,
    output logic             q_push,
    output logic [PIX_W-1:0] q_data,
    output shape_t           shape
);

    logic [DIM_W-1:0]   w0_reg;
    logic [DIM_W-1:0]   w0_next;
    logic [DIM_W-1:0]   h0_reg;
    logic [DIM_W-1:0]   h0_next;
    logic               cfg_hit;
    logic [LEVEL_W-1:0] nlev;

    assign cfg.ready = 1'b1;

    // A write to a known register changes the geometry and restarts the frame.
    always_comb
    begin
        w0_next = w0_reg;
        h0_next = h0_reg;
        cfg_hit = 1'b0;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_IMAGE_WIDTH:
                begin
                    w0_next = clamp_dim(cfg.data);
                    cfg_hit = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    h0_next = clamp_dim(cfg.data);
                    cfg_hit = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w0_reg <= DIM_W'(MAX_DIM);
            h0_reg <= DIM_W'(MAX_DIM);
        end
        else
        begin
            w0_reg <= w0_next;
            h0_reg <= h0_next;
        end
    end

    // Every level that is still larger than 1x1 feeds one more stage.
    always_comb
    begin
        nlev = '0;
        for (int k = 0; k < MAX_LEVELS; k++)
        begin
            if (dim_at(w0_reg, LEVEL_W'(k)) > DIM_W'(1) ||
                dim_at(h0_reg, LEVEL_W'(k)) > DIM_W'(1))
            begin
                nlev = nlev + LEVEL_W'(1);
            end
        end
    end

    assign shape.w0    = w0_reg;
    assign shape.h0    = h0_reg;
    assign shape.nlev  = nlev;
    assign shape.clear = cfg_hit;

    assign pix.ready = !q_full;
    assign q_push    = pix.valid && !q_full;
    assign q_data    = pix.pixel;

endmodule

// ===== design/bfmc_back.sv =====
// Back end: steps one pixel down the chain of stages and drives the result register.
`timescale 1ns / 1ps

module bfmc_back import bfmc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  shape_t           shape,
    input  logic             q_valid,
    input  logic [PIX_W-1:0] q_data,
    output logic             q_pop,
    bfmc_mip_if.source       mip
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_STAGE = 5'b00010,
        ST_VERT  = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_FLUSH = 5'b10000
    } back_state_t;

    back_state_t            state_reg, state_next;
    logic [STAGE_W-1:0]     s_reg, s_next;
    logic [DIM_W-1:0]       base_reg, base_next;
    logic [PIX_W-1:0]       cur_reg, cur_next;
    logic [HSUM_W-1:0]      hsum_reg, hsum_next;
    logic [OUT_COORD_W-1:0] ox_reg, ox_next;
    logic [OUT_COORD_W-1:0] oy_reg, oy_next;
    logic [PIX_W-1:0]       res_reg, res_next;

    logic                   pend_valid_reg, pend_valid_next;
    logic [LEVEL_W-1:0]     pend_level_reg, pend_level_next;
    logic [OUT_COORD_W-1:0] pend_col_reg, pend_col_next;
    logic [OUT_COORD_W-1:0] pend_row_reg, pend_row_next;
    logic [PIX_W-1:0]       pend_pix_reg, pend_pix_next;
    logic                   pend_done_reg, pend_done_next;

    logic                   out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]     out_level_reg, out_level_next;
    logic [OUT_COORD_W-1:0] out_col_reg, out_col_next;
    logic [OUT_COORD_W-1:0] out_row_reg, out_row_next;
    logic [PIX_W-1:0]       out_pix_reg, out_pix_next;
    logic                   out_done_reg, out_done_next;
    logic                   out_last_reg, out_last_next;

    logic [COORD_W-1:0]     col_reg [MAX_LEVELS];
    logic [COORD_W-1:0]     row_reg [MAX_LEVELS];
    logic [PIX_W-1:0]       held_reg [MAX_LEVELS];

    logic [LEVEL_W-1:0]     s_ext, s_plus;
    logic [DIM_W-1:0]       w, h, nw, nh;
    logic [COORD_W-1:0]     sx, sy;
    logic [DIM_W-1:0]       sx_inc, sy_inc;
    logic [COORD_W-1:0]     col_wr, row_wr;
    logic                   cnt_we, held_we;
    logic                   sx_in_pair, sy_in_pair;
    logic                   hready;
    logic [HSUM_W-1:0]      hsum;
    logic [OUT_COORD_W-1:0] ox;
    logic [PIX_W-1:0]       res_h, res_v;
    logic [HSUM_CH_W:0]     vsum;
    logic [HSUM_W-1:0]      ram_rdata;
    logic [COORD_W-1:0]     ram_addr;
    logic                   ram_we, ram_re;
    logic                   out_free, last_stage;

    bfmc_ram #(
        .WIDTH (HSUM_W),
        .DEPTH (MAX_DIM)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (hsum),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // Per-stage geometry and position of the source pixel at stage s_reg.
    always_comb
    begin
        s_ext      = LEVEL_W'(s_reg);
        s_plus     = s_ext + LEVEL_W'(1);
        w          = dim_at(shape.w0, s_ext);
        h          = dim_at(shape.h0, s_ext);
        nw         = dim_at(shape.w0, s_plus);
        nh         = dim_at(shape.h0, s_plus);
        sx         = col_reg[s_reg];
        sy         = row_reg[s_reg];
        sx_inc     = DIM_W'(sx) + DIM_W'(1);
        sy_inc     = DIM_W'(sy) + DIM_W'(1);
        last_stage = (s_plus == shape.nlev);
        out_free   = !out_valid_reg || mip.ready;

        if (sx_inc >= w)
        begin
            col_wr = '0;
            row_wr = (sy_inc >= h) ? '0 : sy_inc[COORD_W-1:0];
        end
        else
        begin
            col_wr = sx_inc[COORD_W-1:0];
            row_wr = sy;
        end

        // A lower level is at most half of MAX_DIM, so twice its size fits DIM_W bits.
        sx_in_pair = ({1'b0, sx} < {nw[DIM_W-2:0], 1'b0});
        sy_in_pair = ({1'b0, sy} < {nh[DIM_W-2:0], 1'b0});

        hsum   = '0;
        ox     = '0;
        hready = 1'b0;
        if (w == DIM_W'(1))
        begin
            // Single column: the pixel pairs with itself.
            for (int c = 0; c < CH_N; c++)
            begin
                hsum[c*HSUM_CH_W +: HSUM_CH_W] = {1'b0, cur_reg[c*CH_W +: CH_W], 1'b0};
            end
            hready = 1'b1;
        end
        else if (sx_in_pair && sx[0])
        begin
            for (int c = 0; c < CH_N; c++)
            begin
                hsum[c*HSUM_CH_W +: HSUM_CH_W] =
                    HSUM_CH_W'(cur_reg[c*CH_W +: CH_W]) +
                    HSUM_CH_W'(held_reg[s_reg][c*CH_W +: CH_W]);
            end
            ox     = sx[COORD_W-1:1];
            hready = 1'b1;
        end

        held_we  = (w != DIM_W'(1)) && sx_in_pair && !sx[0];
        ram_addr = COORD_W'(base_reg + DIM_W'(ox));

        for (int c = 0; c < CH_N; c++)
        begin
            res_h[c*CH_W +: CH_W] = hsum[c*HSUM_CH_W + 1 +: CH_W];
        end

        vsum = '0;
        for (int c = 0; c < CH_N; c++)
        begin
            vsum = {1'b0, hsum_reg[c*HSUM_CH_W +: HSUM_CH_W]} +
                   {1'b0, ram_rdata[c*HSUM_CH_W +: HSUM_CH_W]};
            res_v[c*CH_W +: CH_W] = vsum[2 +: CH_W];
        end
    end

    // Sequencer: one stage per pass, a result leaves through a one-deep pending slot.
    always_comb
    begin
        state_next      = state_reg;
        s_next          = s_reg;
        base_next       = base_reg;
        cur_next        = cur_reg;
        hsum_next       = hsum_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        res_next        = res_reg;
        pend_valid_next = pend_valid_reg;
        pend_level_next = pend_level_reg;
        pend_col_next   = pend_col_reg;
        pend_row_next   = pend_row_reg;
        pend_pix_next   = pend_pix_reg;
        pend_done_next  = pend_done_reg;
        out_valid_next  = out_valid_reg && !mip.ready;
        out_level_next  = out_level_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        out_pix_next    = out_pix_reg;
        out_done_next   = out_done_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        cnt_we          = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_data;
                    s_next     = '0;
                    base_next  = '0;
                    state_next = ST_STAGE;
                end
            end
            ST_STAGE:
            begin
                state_next = pend_valid_reg ? ST_FLUSH : ST_IDLE;
                if (s_ext < shape.nlev)
                begin
                    cnt_we = 1'b1;
                    if (hready)
                    begin
                        if (h == DIM_W'(1))
                        begin
                            res_next   = res_h;
                            ox_next    = ox;
                            oy_next    = '0;
                            state_next = ST_EMIT;
                        end
                        else if (sy_in_pair)
                        begin
                            if (!sy[0])
                            begin
                                ram_we = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                hsum_next  = hsum;
                                ox_next    = ox;
                                oy_next    = sy[COORD_W-1:1];
                                state_next = ST_VERT;
                            end
                        end
                    end
                end
            end
            ST_VERT:
            begin
                res_next   = res_v;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_level_next = pend_level_reg;
                        out_col_next   = pend_col_reg;
                        out_row_next   = pend_row_reg;
                        out_pix_next   = pend_pix_reg;
                        out_done_next  = pend_done_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_level_next = s_plus;
                    pend_col_next   = ox_reg;
                    pend_row_next   = oy_reg;
                    pend_pix_next   = res_reg;
                    pend_done_next  = last_stage;
                    cur_next        = res_reg;
                    if (last_stage)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        s_next     = s_reg + STAGE_W'(1);
                        base_next  = base_reg + nw;
                        state_next = ST_STAGE;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_level_next  = pend_level_reg;
                    out_col_next    = pend_col_reg;
                    out_row_next    = pend_row_reg;
                    out_pix_next    = pend_pix_reg;
                    out_done_next   = pend_done_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg          <= s_next;
        base_reg       <= base_next;
        cur_reg        <= cur_next;
        hsum_reg       <= hsum_next;
        ox_reg         <= ox_next;
        oy_reg         <= oy_next;
        res_reg        <= res_next;
        pend_level_reg <= pend_level_next;
        pend_col_reg   <= pend_col_next;
        pend_row_reg   <= pend_row_next;
        pend_pix_reg   <= pend_pix_next;
        pend_done_reg  <= pend_done_next;
        out_level_reg  <= out_level_next;
        out_col_reg    <= out_col_next;
        out_row_reg    <= out_row_next;
        out_pix_reg    <= out_pix_next;
        out_done_reg   <= out_done_next;
        out_last_reg   <= out_last_next;
        if (held_we && state_reg == ST_STAGE && s_ext < shape.nlev)
        begin
            held_reg[s_reg] <= cur_reg;
        end
    end

    // Stage positions return to the frame start on reset and on a size change.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_LEVELS; k++)
            begin
                col_reg[k] <= '0;
                row_reg[k] <= '0;
            end
        end
        else if (shape.clear)
        begin
            for (int k = 0; k < MAX_LEVELS; k++)
            begin
                col_reg[k] <= '0;
                row_reg[k] <= '0;
            end
        end
        else if (cnt_we)
        begin
            col_reg[s_reg] <= col_wr;
            row_reg[s_reg] <= row_wr;
        end
    end

    assign mip.valid       = out_valid_reg;
    assign mip.level       = out_level_reg;
    assign mip.col         = out_col_reg;
    assign mip.row         = out_row_reg;
    assign mip.mip_pixel   = out_pix_reg;
    assign mip.image_done  = out_done_reg;
    assign mip.last_of_run = out_last_reg;

endmodule

// ===== design/bfmc_checker.sv =====
// Port-level checker of the mip chain and its bind to the top level.
`timescale 1ns / 1ps

module bfmc_checker import bfmc_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   mip_valid,
    input logic                   mip_ready,
    input logic [LEVEL_W-1:0]     level,
    input logic [OUT_COORD_W-1:0] col,
    input logic [OUT_COORD_W-1:0] row,
    input logic [PIX_W-1:0]       mip_pixel,
    input logic                   image_done,
    input logic                   last_of_run
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mip_valid && !mip_ready |=> mip_valid)
        else $error("result request dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mip_valid && !mip_ready |=>
            $stable({level, col, row, mip_pixel, image_done, last_of_run}))
        else $error("result payload changed while stalled");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        mip_valid && image_done |-> last_of_run)
        else $error("final level pixel not marked as last of its run");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        mip_valid |-> (level != '0) && (level <= LEVEL_W'(MAX_LEVELS)))
        else $error("result level out of range");

endmodule

bind box_filter_mip_chain_core bfmc_checker u_bfmc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .mip_valid   (mip.valid),
    .mip_ready   (mip.ready),
    .level       (mip.level),
    .col         (mip.col),
    .row         (mip.row),
    .mip_pixel   (mip.mip_pixel),
    .image_done  (mip.image_done),
    .last_of_run (mip.last_of_run)
);
